[sv/dc_motor_drive_controller_core_macros.svh]
// Assertion macros for the motor drive controller core.
// Used by the top level only; expects i_clk and i_rst_n in scope.
`ifndef DC_MOTOR_DRIVE_CONTROLLER_CORE_MACROS_SVH
`define DC_MOTOR_DRIVE_CONTROLLER_CORE_MACROS_SVH

// same-cycle implication
`define DMDC_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("dmdc assertion failed");

// next-cycle implication
`define DMDC_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("dmdc assertion failed");

`endif

[sv/dmdc_pkg.sv]
// Shared types, constants and helpers of the motor drive controller.
// No dependencies.
`default_nettype none

package dmdc_pkg;

    localparam int ENC_PERIOD = 65535;
    localparam logic signed [32:0] FOLD_PERIOD = 33'(ENC_PERIOD);
    localparam logic signed [32:0] FOLD_HALF   = 33'(ENC_PERIOD / 2);

    localparam logic [16:0]        BRAKE_K        = 17'd91750;
    localparam logic signed [31:0] POS_SPEED_MAX  = 32'sd3276800;
    localparam logic signed [31:0] HOMING_SPEED   = -32'sd10485760;
    localparam logic [30:0]        HOMING_CURRENT = 31'd52429;
    localparam logic signed [31:0] STALL_SPEED    = 32'sd131072;
    localparam logic [8:0]         STALL_DONE     = 9'd500;
    localparam logic [8:0]         STALL_MAX      = 9'd511;
    localparam logic [31:0]        HOME_TARGET    = 32'd8192;

    localparam int SQ_STEPS = 40;
    localparam int SQ_CNT_W = 6;

    localparam logic [30:0] RAMP_STEP_RESET = 31'd3276800;

    localparam logic [1:0] MODE_SPEED = 2'd0;
    localparam logic [1:0] MODE_POS   = 2'd1;
    localparam logic [1:0] MODE_HOME  = 2'd2;
    localparam logic [1:0] MODE_BAD   = 2'd3;

    localparam logic [3:0] REG_SPEED_GAIN_P = 4'd0;
    localparam logic [3:0] REG_SPEED_GAIN_I = 4'd1;
    localparam logic [3:0] REG_DRIVE_LIMIT  = 4'd2;
    localparam logic [3:0] REG_RAMP_UP      = 4'd3;
    localparam logic [3:0] REG_RAMP_DOWN    = 4'd4;
    localparam logic [3:0] REG_POS_GAIN_P   = 4'd5;
    localparam logic [3:0] REG_POS_GAIN_D   = 4'd6;
    localparam logic [3:0] REG_START_MODE   = 4'd7;

    typedef enum logic [4:0] {
        S_IDLE, S_FOLD, S_ZERO, S_PERR, S_PP, S_PD, S_K, S_RLO, S_RHI,
        S_SQI, S_SQ, S_BRAKE, S_RAMP, S_HOME, S_SERR, S_GI, S_GP, S_DRIVE, S_OUT
    } t_state;

    typedef enum logic [4:0] {
        OP_NONE, OP_LOAD, OP_FOLD, OP_ZERO, OP_PERR, OP_MUL_PP, OP_MUL_PD,
        OP_MUL_K, OP_MUL_RLO, OP_MUL_RHI, OP_SQ_INIT, OP_SQ_STEP, OP_BRAKE,
        OP_RAMP, OP_HOME, OP_SERR, OP_MUL_GI, OP_MUL_GP, OP_DRIVE
    } t_op;

    typedef struct packed {
        logic [1:0] mode;
        logic       en;
        logic       sq_last;
    } t_dp_status;

    // symmetric clamp to +-lim
    function automatic logic signed [31:0] clamp_sym(input logic signed [59:0] v,
                                                     input logic [30:0] lim);
        logic signed [59:0] l;
        logic signed [59:0] r;
        l = $signed({29'b0, lim});
        if (v > l) begin
            r = l;
        end else if (v < -l) begin
            r = -l;
        end else begin
            r = v;
        end
        return r[31:0];
    endfunction

endpackage

`default_nettype wire

[sv/dmdc_ctrl.sv]
// Sequencer of the motor drive controller: one step per state.
// Depends on dmdc_pkg.
`default_nettype none

module dmdc_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    input  wire logic               i_out_stall,
    input  wire dmdc_pkg::t_dp_status i_status,
    output dmdc_pkg::t_op           o_op,
    output logic                    o_in_stall,
    output logic                    o_out_valid
);

    dmdc_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dmdc_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            dmdc_pkg::S_IDLE:  if (i_in_valid) n_state = dmdc_pkg::S_FOLD;
            dmdc_pkg::S_FOLD: begin
                if (!i_status.en) begin
                    n_state = dmdc_pkg::S_ZERO;
                end else begin
                    unique case (i_status.mode)
                        dmdc_pkg::MODE_SPEED: n_state = dmdc_pkg::S_RAMP;
                        dmdc_pkg::MODE_POS:   n_state = dmdc_pkg::S_PERR;
                        dmdc_pkg::MODE_HOME:  n_state = dmdc_pkg::S_HOME;
                        default:              n_state = dmdc_pkg::S_ZERO;
                    endcase
                end
            end
            dmdc_pkg::S_ZERO:  n_state = dmdc_pkg::S_OUT;
            dmdc_pkg::S_PERR:  n_state = dmdc_pkg::S_PP;
            dmdc_pkg::S_PP:    n_state = dmdc_pkg::S_PD;
            dmdc_pkg::S_PD:    n_state = dmdc_pkg::S_K;
            dmdc_pkg::S_K:     n_state = dmdc_pkg::S_RLO;
            dmdc_pkg::S_RLO:   n_state = dmdc_pkg::S_RHI;
            dmdc_pkg::S_RHI:   n_state = dmdc_pkg::S_SQI;
            dmdc_pkg::S_SQI:   n_state = dmdc_pkg::S_SQ;
            dmdc_pkg::S_SQ:    if (i_status.sq_last) n_state = dmdc_pkg::S_BRAKE;
            dmdc_pkg::S_BRAKE: n_state = dmdc_pkg::S_RAMP;
            dmdc_pkg::S_RAMP:  n_state = dmdc_pkg::S_SERR;
            dmdc_pkg::S_HOME:  n_state = dmdc_pkg::S_SERR;
            dmdc_pkg::S_SERR:  n_state = dmdc_pkg::S_GI;
            dmdc_pkg::S_GI:    n_state = dmdc_pkg::S_GP;
            dmdc_pkg::S_GP:    n_state = dmdc_pkg::S_DRIVE;
            dmdc_pkg::S_DRIVE: n_state = dmdc_pkg::S_OUT;
            dmdc_pkg::S_OUT:   if (!i_out_stall) n_state = dmdc_pkg::S_IDLE;
            default:           n_state = dmdc_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_op        = dmdc_pkg::OP_NONE;
        o_in_stall  = 1'b1;
        o_out_valid = 1'b0;
        unique case (r_state)
            dmdc_pkg::S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) o_op = dmdc_pkg::OP_LOAD;
            end
            dmdc_pkg::S_FOLD:  o_op = dmdc_pkg::OP_FOLD;
            dmdc_pkg::S_ZERO:  o_op = dmdc_pkg::OP_ZERO;
            dmdc_pkg::S_PERR:  o_op = dmdc_pkg::OP_PERR;
            dmdc_pkg::S_PP:    o_op = dmdc_pkg::OP_MUL_PP;
            dmdc_pkg::S_PD:    o_op = dmdc_pkg::OP_MUL_PD;
            dmdc_pkg::S_K:     o_op = dmdc_pkg::OP_MUL_K;
            dmdc_pkg::S_RLO:   o_op = dmdc_pkg::OP_MUL_RLO;
            dmdc_pkg::S_RHI:   o_op = dmdc_pkg::OP_MUL_RHI;
            dmdc_pkg::S_SQI:   o_op = dmdc_pkg::OP_SQ_INIT;
            dmdc_pkg::S_SQ:    o_op = dmdc_pkg::OP_SQ_STEP;
            dmdc_pkg::S_BRAKE: o_op = dmdc_pkg::OP_BRAKE;
            dmdc_pkg::S_RAMP:  o_op = dmdc_pkg::OP_RAMP;
            dmdc_pkg::S_HOME:  o_op = dmdc_pkg::OP_HOME;
            dmdc_pkg::S_SERR:  o_op = dmdc_pkg::OP_SERR;
            dmdc_pkg::S_GI:    o_op = dmdc_pkg::OP_MUL_GI;
            dmdc_pkg::S_GP:    o_op = dmdc_pkg::OP_MUL_GP;
            dmdc_pkg::S_DRIVE: o_op = dmdc_pkg::OP_DRIVE;
            dmdc_pkg::S_OUT:   o_out_valid = 1'b1;
            default:           o_op = dmdc_pkg::OP_NONE;
        endcase
    end

endmodule

`default_nettype wire

[sv/dmdc_dp.sv]
// Datapath of the motor drive controller: registers, one shared multiplier,
// a radix-2 square root and the loop arithmetic. Depends on dmdc_pkg.
`default_nettype none

module dmdc_dp (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire dmdc_pkg::t_op      i_op,
    input  wire logic signed [31:0] i_speed_command,
    input  wire logic signed [31:0] i_measured_speed,
    input  wire logic signed [31:0] i_measured_position,
    input  wire logic               i_enable,
    input  wire logic               i_cfg_we,
    input  wire logic [3:0]         i_cfg_index,
    input  wire logic [31:0]        i_cfg_data,
    output dmdc_pkg::t_dp_status    o_status,
    output logic signed [31:0]      o_drive,
    output logic [1:0]              o_active_mode,
    output logic                    o_homing_finished
);

    // configuration
    logic [23:0] r_gain_sp, r_gain_si, r_gain_pp, r_gain_pd;
    logic [30:0] r_limit, r_ramp_up, r_ramp_dn;
    logic [1:0]  r_mode;

    // tick state
    logic signed [31:0] r_ramped, r_integ;
    logic [31:0]        r_prev_pos, r_acc, r_target, r_prev_err;
    logic [8:0]         r_stall;

    // working registers
    logic signed [31:0] r_spd, r_cmd, r_err;
    logic [31:0]        r_pos, r_mag;
    logic               r_en;
    logic signed [32:0] r_derr, r_serr;
    logic signed [67:0] r_prod;
    logic signed [59:0] r_pid;
    logic [15:0]        r_krd_hi;
    logic [63:0]        r_rlo;
    logic [79:0]        r_rad;
    logic [41:0]        r_rem;
    logic [39:0]        r_root;
    logic [dmdc_pkg::SQ_CNT_W-1:0] r_cnt;
    logic signed [31:0] r_drive;
    logic               r_fin;

    logic signed [33:0] mul_a, mul_b;
    logic signed [67:0] product;

    // shared multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (i_op)
            dmdc_pkg::OP_MUL_PP: begin
                mul_a = $signed({{2{r_err[31]}}, r_err});
                mul_b = $signed({10'b0, r_gain_pp});
            end
            dmdc_pkg::OP_MUL_PD: begin
                mul_a = $signed({r_derr[32], r_derr});
                mul_b = $signed({10'b0, r_gain_pd});
            end
            dmdc_pkg::OP_MUL_K: begin
                mul_a = $signed({17'b0, dmdc_pkg::BRAKE_K});
                mul_b = $signed({3'b0, r_ramp_dn});
            end
            dmdc_pkg::OP_MUL_RLO: begin
                mul_a = $signed({2'b0, r_prod[31:0]});
                mul_b = $signed({2'b0, r_mag});
            end
            dmdc_pkg::OP_MUL_RHI: begin
                mul_a = $signed({18'b0, r_krd_hi});
                mul_b = $signed({2'b0, r_mag});
            end
            dmdc_pkg::OP_MUL_GI: begin
                mul_a = $signed({r_serr[32], r_serr});
                mul_b = $signed({10'b0, r_gain_si});
            end
            dmdc_pkg::OP_MUL_GP: begin
                mul_a = $signed({r_serr[32], r_serr});
                mul_b = $signed({10'b0, r_gain_sp});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign product = mul_a * mul_b;

    // step arithmetic
    logic signed [32:0] fold_d;
    logic [31:0]        enc_step, perr;
    logic [43:0]        sq_rem2, sq_trial;
    logic [59:0]        pid_abs;
    logic [39:0]        brake_mag;
    logic signed [31:0] brake_cmd;
    logic signed [33:0] rp_soft, rp_cmd, rp_up, rp_dn;
    logic signed [41:0] int_sum, drv_sum;
    logic signed [31:0] drv_lim, drv_home;
    logic [8:0]         stall_nx;

    always_comb begin
        enc_step = r_pos - r_prev_pos;
        fold_d   = $signed({enc_step[31], enc_step});
        if (fold_d > dmdc_pkg::FOLD_HALF) begin
            fold_d = fold_d - dmdc_pkg::FOLD_PERIOD;
        end else if (fold_d < -dmdc_pkg::FOLD_HALF) begin
            fold_d = fold_d + dmdc_pkg::FOLD_PERIOD;
        end

        perr = r_target - r_acc;

        sq_rem2  = {r_rem, r_rad[79:78]};
        sq_trial = {2'b0, r_root, 2'b01};

        // braking curve versus PD output
        pid_abs   = r_pid[59] ? 60'(-r_pid) : 60'(r_pid);
        brake_mag = (r_root > 40'(dmdc_pkg::POS_SPEED_MAX))
                    ? 40'(dmdc_pkg::POS_SPEED_MAX) : r_root;
        if ({20'b0, r_root} < pid_abs) begin
            brake_cmd = r_err[31] ? -$signed(brake_mag[31:0]) : $signed(brake_mag[31:0]);
        end else begin
            brake_cmd = dmdc_pkg::clamp_sym(r_pid, dmdc_pkg::POS_SPEED_MAX[30:0]);
        end

        rp_soft = $signed({{2{r_ramped[31]}}, r_ramped});
        rp_cmd  = $signed({{2{r_cmd[31]}}, r_cmd});
        rp_up   = $signed({3'b0, r_ramp_up});
        rp_dn   = $signed({3'b0, r_ramp_dn});
        if (rp_soft < rp_cmd - rp_up) begin
            rp_soft = rp_soft + rp_up;
        end else if (rp_soft > rp_cmd + rp_dn) begin
            rp_soft = rp_soft - rp_dn;
        end else begin
            rp_soft = rp_cmd;
        end

        // floor of product / 2^16 plus integrator
        int_sum  = $signed(r_prod[57:16]) + $signed({{10{r_integ[31]}}, r_integ});
        drv_sum  = int_sum;
        drv_lim  = dmdc_pkg::clamp_sym($signed({{18{drv_sum[41]}}, drv_sum}), r_limit);
        drv_home = dmdc_pkg::clamp_sym($signed({{28{drv_lim[31]}}, drv_lim}),
                                       dmdc_pkg::HOMING_CURRENT);

        if (r_spd <= dmdc_pkg::STALL_SPEED && r_spd >= -dmdc_pkg::STALL_SPEED) begin
            stall_nx = (r_stall < dmdc_pkg::STALL_MAX) ? r_stall + 9'd1 : r_stall;
        end else begin
            stall_nx = '0;
        end
    end

    // configuration and tick state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_sp  <= '0;
            r_gain_si  <= '0;
            r_limit    <= '0;
            r_ramp_up  <= dmdc_pkg::RAMP_STEP_RESET;
            r_ramp_dn  <= dmdc_pkg::RAMP_STEP_RESET;
            r_gain_pp  <= '0;
            r_gain_pd  <= '0;
            r_mode     <= dmdc_pkg::MODE_SPEED;
            r_ramped   <= '0;
            r_integ    <= '0;
            r_prev_pos <= '0;
            r_acc      <= '0;
            r_target   <= '0;
            r_prev_err <= '0;
            r_stall    <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    dmdc_pkg::REG_SPEED_GAIN_P: r_gain_sp <= i_cfg_data[23:0];
                    dmdc_pkg::REG_SPEED_GAIN_I: r_gain_si <= i_cfg_data[23:0];
                    dmdc_pkg::REG_DRIVE_LIMIT:  r_limit   <= i_cfg_data[30:0];
                    dmdc_pkg::REG_RAMP_UP:      r_ramp_up <= i_cfg_data[30:0];
                    dmdc_pkg::REG_RAMP_DOWN:    r_ramp_dn <= i_cfg_data[30:0];
                    dmdc_pkg::REG_POS_GAIN_P:   r_gain_pp <= i_cfg_data[23:0];
                    dmdc_pkg::REG_POS_GAIN_D:   r_gain_pd <= i_cfg_data[23:0];
                    dmdc_pkg::REG_START_MODE: begin
                        if (i_cfg_data[1:0] != dmdc_pkg::MODE_BAD) r_mode <= i_cfg_data[1:0];
                    end
                    default: ;
                endcase
            end
            case (i_op)
                dmdc_pkg::OP_FOLD: begin
                    r_acc      <= r_acc + fold_d[31:0];
                    r_prev_pos <= r_pos;
                end
                dmdc_pkg::OP_PERR:  r_prev_err <= perr;
                dmdc_pkg::OP_RAMP:  r_ramped <= rp_soft[31:0];
                dmdc_pkg::OP_HOME:  r_ramped <= dmdc_pkg::HOMING_SPEED;
                dmdc_pkg::OP_MUL_GP: begin
                    r_integ <= dmdc_pkg::clamp_sym($signed({{18{int_sum[41]}}, int_sum}),
                                                   r_limit);
                end
                dmdc_pkg::OP_DRIVE: begin
                    if (r_mode == dmdc_pkg::MODE_HOME) begin
                        r_stall <= stall_nx;
                        if (stall_nx >= dmdc_pkg::STALL_DONE) begin
                            r_acc    <= '0;
                            r_target <= dmdc_pkg::HOME_TARGET;
                            r_ramped <= '0;
                            r_integ  <= '0;
                            r_mode   <= dmdc_pkg::MODE_POS;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // working registers, no reset needed
    always_ff @(posedge i_clk) begin
        case (i_op)
            dmdc_pkg::OP_LOAD: begin
                r_cmd <= i_speed_command;
                r_spd <= i_measured_speed;
                r_pos <= i_measured_position;
                r_en  <= i_enable;
            end
            dmdc_pkg::OP_ZERO: begin
                r_drive <= '0;
                r_fin   <= 1'b0;
            end
            dmdc_pkg::OP_PERR: begin
                r_err  <= $signed(perr);
                r_mag  <= perr[31] ? 32'(-perr) : perr;
                r_derr <= $signed({perr[31], perr}) - $signed({r_prev_err[31], r_prev_err});
            end
            dmdc_pkg::OP_MUL_PP: r_prod <= product;
            dmdc_pkg::OP_MUL_PD: begin
                r_prod <= product;
                r_pid  <= r_prod[59:0];
            end
            dmdc_pkg::OP_MUL_K: begin
                r_prod <= product;
                r_pid  <= r_pid + r_prod[59:0];
            end
            dmdc_pkg::OP_MUL_RLO: begin
                r_prod   <= product;
                r_krd_hi <= r_prod[47:32];
            end
            dmdc_pkg::OP_MUL_RHI: begin
                r_prod <= product;
                r_rlo  <= r_prod[63:0];
            end
            dmdc_pkg::OP_SQ_INIT: begin
                r_rad  <= {16'b0, r_rlo} + {r_prod[47:0], 32'b0};
                r_rem  <= '0;
                r_root <= '0;
                r_cnt  <= '0;
            end
            dmdc_pkg::OP_SQ_STEP: begin
                if (sq_rem2 >= sq_trial) begin
                    r_rem  <= 42'(sq_rem2 - sq_trial);
                    r_root <= {r_root[38:0], 1'b1};
                end else begin
                    r_rem  <= sq_rem2[41:0];
                    r_root <= {r_root[38:0], 1'b0};
                end
                r_rad <= {r_rad[77:0], 2'b00};
                r_cnt <= r_cnt + 1'b1;
            end
            dmdc_pkg::OP_BRAKE: r_cmd <= brake_cmd;
            dmdc_pkg::OP_SERR: begin
                r_serr <= $signed({r_ramped[31], r_ramped}) - $signed({r_spd[31], r_spd});
            end
            dmdc_pkg::OP_MUL_GI: r_prod <= product;
            dmdc_pkg::OP_MUL_GP: r_prod <= product;
            dmdc_pkg::OP_DRIVE: begin
                if (r_mode == dmdc_pkg::MODE_HOME && stall_nx >= dmdc_pkg::STALL_DONE) begin
                    r_drive <= '0;
                    r_fin   <= 1'b1;
                end else if (r_mode == dmdc_pkg::MODE_HOME) begin
                    r_drive <= drv_home;
                    r_fin   <= 1'b0;
                end else begin
                    r_drive <= drv_lim;
                    r_fin   <= 1'b0;
                end
            end
            default: ;
        endcase
    end

    assign o_status.mode    = r_mode;
    assign o_status.en      = r_en;
    assign o_status.sq_last = (r_cnt == dmdc_pkg::SQ_CNT_W'(dmdc_pkg::SQ_STEPS - 1));

    assign o_drive           = r_drive;
    assign o_active_mode     = r_mode;
    assign o_homing_finished = r_fin;

endmodule

`default_nettype wire

[sv/dc_motor_drive_controller_core.sv]
// Motor drive controller top level: sequencer plus datapath.
// Depends on dmdc_pkg, dmdc_ctrl, dmdc_dp and the macros header.
`default_nettype none

// One control tick per input beat. Each beat folds the encoder change into
// +-ENC_PERIOD/2, accumulates it, then runs the active mode: speed (ramp + PI),
// position (PD limited by a square-root braking curve, feeding the speed loop)
// or homing (fixed -160 rpm, current limited to 0.8, stall detect over 500
// ticks, then zero the position, target 8192, switch to position mode).
// With enable low the drive is 0 and only the encoder fold runs.
// All speeds, drive and limits are signed Q16.16; gains unsigned Q8.16.
// One beat is processed at a time; the input stalls until the result beat has
// been taken. Position mode takes longest, where the 40-step bit-serial
// square root of the 80-bit braking radicand dominates. The next beat is taken
// only in idle. All multiplies share one 34x34 multiplier, one per cycle.
// Configuration writes are always ready; index 7 loads the mode immediately
// (code 3 ignored), indexes past 7 ignored.
// Write configuration only while no beat is in flight.
module dc_motor_drive_controller_core (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // input beat
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic signed [31:0] i_speed_command,
    input  wire logic signed [31:0] i_measured_speed,
    input  wire logic signed [31:0] i_measured_position,
    input  wire logic               i_enable,
    // result beat
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic signed [31:0]      o_drive,
    output logic [1:0]              o_active_mode,
    output logic                    o_homing_finished,
    // configuration writes
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [3:0]         i_cfg_index,
    input  wire logic [31:0]        i_cfg_data
);

`include "dc_motor_drive_controller_core_macros.svh"

    dmdc_pkg::t_op        op;
    dmdc_pkg::t_dp_status status;

    assign o_cfg_ready = 1'b1;

    dmdc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_stall (i_out_stall),
        .i_status    (status),
        .o_op        (op),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid)
    );

    dmdc_dp u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_op                (op),
        .i_speed_command     (i_speed_command),
        .i_measured_speed    (i_measured_speed),
        .i_measured_position (i_measured_position),
        .i_enable            (i_enable),
        .i_cfg_we            (i_cfg_valid & o_cfg_ready),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data),
        .o_status            (status),
        .o_drive             (o_drive),
        .o_active_mode       (o_active_mode),
        .o_homing_finished   (o_homing_finished)
    );

    // a pending result blocks new input
    `DMDC_ASSERT_IMP(a_busy_while_out, o_out_valid, o_in_stall)
    // accepted beat never yields a result in the next cycle
    `DMDC_ASSERT_NXT(a_no_instant_out, i_in_valid && !o_in_stall, !o_out_valid)
    // homing finish reports position mode and zero drive
    `DMDC_ASSERT_IMP(a_home_done, o_out_valid && o_homing_finished,
                     o_active_mode == dmdc_pkg::MODE_POS && o_drive == 32'sd0)

endmodule

`default_nettype wire
